### sv/dcdl_pkg.sv
// Package for the duty-cycle debt limiter: field widths, codes, reset values and payload types.
// It depends on nothing else; the top level refers to it by scoped names.
`default_nettype none

package dcdl_pkg;

    // Widths fixed by the interface.
    localparam int SPAN_W     = 37;
    localparam int TOTAL_W    = 48;
    localparam int DEBT_W     = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int HALF_W     = 16;
    localparam int PROD_W     = SPAN_W + HALF_W;

    // Default width of the scripted clock.
    localparam int TIME_BITS_DEF = 48;

    // One day in microseconds; longer spans are flagged and ignored.
    localparam logic [SPAN_W-1:0] DAY_US = SPAN_W'(64'd86_400_000_000);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [DEBT_W-1:0]  COUNT_MAX = '1;

    // Event kinds.
    localparam logic [1:0] KIND_WORK  = 2'd0;
    localparam logic [1:0] KIND_IDLE  = 2'd1;
    localparam logic [1:0] KIND_HOST  = 2'd2;
    localparam logic [1:0] KIND_RESET = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBT_CAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_FLOOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_CAP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_GAP   = 3'd5;

    // Register reset values.
    localparam logic [DEBT_W-1:0] DEBT_CAP_RST    = 32'd1_000_000;
    localparam logic [DEBT_W-1:0] SLEEP_FLOOR_RST = 32'd1_000;
    localparam logic [DEBT_W-1:0] SLEEP_CAP_RST   = 32'd100_000;
    localparam logic [DEBT_W-1:0] STALE_GAP_RST   = 32'd1_000_000;

    // One event of the script.
    typedef struct packed {
        logic [1:0]        kind;
        logic [SPAN_W-1:0] span_us;
        logic              last_event;
    } in_item_t;

    // Running totals reported after each event.
    typedef struct packed {
        logic [TOTAL_W-1:0] compute_us;
        logic [TOTAL_W-1:0] idle_us;
        logic [TOTAL_W-1:0] wall_us;
        logic [DEBT_W-1:0]  debt_us;
        logic [DEBT_W-1:0]  sleep_count;
        logic               span_error;
        logic               last_result;
    } out_item_t;

endpackage

`default_nettype wire

### sv/duty_cycle_debt_limiter.sv
// Top level of the duty-cycle debt limiter: pipeline, limiter state and configuration registers.
// Depends on dcdl_pkg for widths, codes and the payload structs.
`default_nettype none

//  Channel   Ports                          Direction  Carries
//  input     s_valid s_ready s_data         in         one script event (in_item_t)
//  result    m_valid m_ready m_data         out        running totals (out_item_t)
//  config    cfg_we cfg_addr cfg_wdata      in         register writes, no read-back
//
// One event is accepted per cycle while s_ready is high.
// Stages: input register, partial products of span by the idle factor, clipped debt
// charge, then the state update, made on the edge that loads the result register.
// Each stage holds its transaction while the next is full, so stalls ripple back from m_ready.
// Reset clears the handshake, the limiter state and the registers to their defaults.
module duty_cycle_debt_limiter #(
    parameter int TIME_BITS = dcdl_pkg::TIME_BITS_DEF
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire  dcdl_pkg::in_item_t              s_data,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output dcdl_pkg::out_item_t                   m_data,
    input  wire                                   cfg_we,
    input  wire  [dcdl_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  wire  [dcdl_pkg::CFG_W-1:0]            cfg_wdata
);

    localparam int SW = dcdl_pkg::SPAN_W;
    localparam int TW = dcdl_pkg::TOTAL_W;
    localparam int DW = dcdl_pkg::DEBT_W;
    localparam int HW = dcdl_pkg::HALF_W;
    localparam int PW = dcdl_pkg::PROD_W;

    // Configuration registers.
    logic          enable_reg;
    logic [DW-1:0] idle_factor_reg;
    logic [DW-1:0] debt_cap_reg;
    logic [DW-1:0] sleep_floor_reg;
    logic [DW-1:0] sleep_cap_reg;
    logic [DW-1:0] stale_gap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b0;
            idle_factor_reg <= '0;
            debt_cap_reg    <= dcdl_pkg::DEBT_CAP_RST;
            sleep_floor_reg <= dcdl_pkg::SLEEP_FLOOR_RST;
            sleep_cap_reg   <= dcdl_pkg::SLEEP_CAP_RST;
            stale_gap_reg   <= dcdl_pkg::STALE_GAP_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                dcdl_pkg::CFG_ENABLE:      enable_reg      <= cfg_wdata[0];
                dcdl_pkg::CFG_IDLE_FACTOR: idle_factor_reg <= cfg_wdata;
                dcdl_pkg::CFG_DEBT_CAP:    debt_cap_reg    <= cfg_wdata;
                dcdl_pkg::CFG_SLEEP_FLOOR: sleep_floor_reg <= cfg_wdata;
                dcdl_pkg::CFG_SLEEP_CAP:   sleep_cap_reg   <= cfg_wdata;
                dcdl_pkg::CFG_STALE_GAP:   stale_gap_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline occupancy and the ready chain, from the result register backwards.
    logic v1_reg, v2_reg, v3_reg;
    logic rdy3, rdy2, rdy1, fire3;

    assign rdy3    = !m_valid || m_ready;
    assign rdy2    = !v3_reg || rdy3;
    assign rdy1    = !v2_reg || rdy2;
    assign s_ready = !v1_reg || rdy1;
    assign fire3   = v3_reg && rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            m_valid <= 1'b0;
        end else begin
            if (s_ready) v1_reg  <= s_valid;
            if (rdy1)    v2_reg  <= v1_reg;
            if (rdy2)    v3_reg  <= v2_reg;
            if (rdy3)    m_valid <= v3_reg;
        end
    end

    // Stage one: the accepted transaction.
    logic [1:0]    kind1_reg;
    logic [SW-1:0] span1_reg;
    logic          last1_reg;

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            kind1_reg <= s_data.kind;
            span1_reg <= s_data.span_us;
            last1_reg <= s_data.last_event;
        end
    end

    // Stage two: span times the integer and fraction halves of the idle factor.
    logic [1:0]    kind2_reg;
    logic [SW-1:0] span2_reg;
    logic          last2_reg;
    logic          err2_reg;
    logic          zero2_reg;
    logic [PW-1:0] phi2_reg;
    logic [PW-1:0] plo2_reg;
    logic [PW-1:0] phi_next;
    logic [PW-1:0] plo_next;

    assign phi_next = PW'(span1_reg) * PW'(idle_factor_reg[DW-1:HW]);
    assign plo_next = PW'(span1_reg) * PW'(idle_factor_reg[HW-1:0]);

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            kind2_reg <= kind1_reg;
            span2_reg <= span1_reg;
            last2_reg <= last1_reg;
            err2_reg  <= span1_reg > dcdl_pkg::DAY_US;
            zero2_reg <= span1_reg == '0;
            phi2_reg  <= phi_next;
            plo2_reg  <= plo_next;
        end
    end

    // Stage three: truncated Q16.16 charge, clipped at the debt ceiling.
    logic [1:0]    kind3_reg;
    logic [SW-1:0] span3_reg;
    logic          last3_reg;
    logic          err3_reg;
    logic          zero3_reg;
    logic [DW-1:0] owed3_reg;
    logic [PW:0]   owed_sum;
    logic [DW-1:0] owed_next;

    assign owed_sum  = (PW+1)'(phi2_reg) + (PW+1)'(plo2_reg[PW-1:HW]);
    assign owed_next = (owed_sum > (PW+1)'(debt_cap_reg)) ? debt_cap_reg : owed_sum[DW-1:0];

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            kind3_reg <= kind2_reg;
            span3_reg <= span2_reg;
            last3_reg <= last2_reg;
            err3_reg  <= err2_reg;
            zero3_reg <= zero2_reg;
            owed3_reg <= owed_next;
        end
    end

    // Limiter state.
    logic [TIME_BITS-1:0] cur_reg, cur_next;
    logic [TIME_BITS-1:0] ws_reg, ws_next;
    logic [DW-1:0]        debt_reg, debt_next;
    logic [TW-1:0]        compute_reg, compute_next;
    logic [TW-1:0]        idle_reg, idle_next;
    logic [DW-1:0]        sleeps_reg, sleeps_next;

    // Candidate values for each kind of event.
    logic [TIME_BITS-1:0] cur_span, cur_slept, gap_old, gap_new;
    logic                 stale_old, stale_new, sleep_ok;
    logic [DW-1:0]        debt_open, debt_charged, slept, sleeps_inc;
    logic [DW:0]          charge_sum;
    logic [TW:0]          comp_sum, idle_sum;
    logic [TW-1:0]        comp_sat, idle_sat;

    assign cur_span   = cur_reg + TIME_BITS'(span3_reg);
    assign gap_old    = cur_reg - ws_reg;
    assign gap_new    = cur_span - ws_reg;
    assign stale_old  = gap_old >= TIME_BITS'(stale_gap_reg);
    assign stale_new  = gap_new >= TIME_BITS'(stale_gap_reg);
    assign debt_open  = stale_old ? '0 : debt_reg;

    assign charge_sum   = {1'b0, debt_open} + {1'b0, owed3_reg};
    assign debt_charged = (charge_sum > {1'b0, debt_cap_reg}) ? debt_cap_reg
                                                              : charge_sum[DW-1:0];
    assign comp_sum     = {1'b0, compute_reg} + (TW+1)'(span3_reg);
    assign comp_sat     = comp_sum[TW] ? dcdl_pkg::TOTAL_MAX : comp_sum[TW-1:0];

    assign sleep_ok   = debt_reg >= sleep_floor_reg;
    assign slept      = (debt_reg < sleep_cap_reg) ? debt_reg : sleep_cap_reg;
    assign cur_slept  = cur_reg + TIME_BITS'(slept);
    assign idle_sum   = {1'b0, idle_reg} + (TW+1)'(slept);
    assign idle_sat   = idle_sum[TW] ? dcdl_pkg::TOTAL_MAX : idle_sum[TW-1:0];
    assign sleeps_inc = (sleeps_reg == dcdl_pkg::COUNT_MAX) ? sleeps_reg : sleeps_reg + DW'(1);

    // Select the next state from the event kind; an oversized span changes nothing.
    always_comb begin
        cur_next     = cur_reg;
        ws_next      = ws_reg;
        debt_next    = debt_reg;
        compute_next = compute_reg;
        idle_next    = idle_reg;
        sleeps_next  = sleeps_reg;
        if (!err3_reg) begin
            case (kind3_reg)
                dcdl_pkg::KIND_WORK: begin
                    cur_next = cur_span;
                    if (enable_reg) begin
                        ws_next   = cur_span;
                        debt_next = debt_open;
                        if (!zero3_reg) begin
                            compute_next = comp_sat;
                            debt_next    = debt_charged;
                        end
                    end
                end
                dcdl_pkg::KIND_IDLE: begin
                    if (enable_reg) begin
                        ws_next = cur_reg;
                        if (sleep_ok) begin
                            cur_next    = cur_slept;
                            ws_next     = cur_slept;
                            idle_next   = idle_sat;
                            debt_next   = debt_reg - slept;
                            sleeps_next = sleeps_inc;
                        end
                    end
                end
                dcdl_pkg::KIND_HOST: begin
                    cur_next = cur_span;
                    if (enable_reg) begin
                        ws_next = cur_span;
                        if (stale_new) debt_next = '0;
                    end
                end
                dcdl_pkg::KIND_RESET: begin
                    if (enable_reg) begin
                        debt_next = '0;
                        ws_next   = cur_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // The state moves once per transaction, as it enters the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg     <= '0;
            ws_reg      <= '0;
            debt_reg    <= '0;
            compute_reg <= '0;
            idle_reg    <= '0;
            sleeps_reg  <= '0;
        end else if (fire3) begin
            cur_reg     <= cur_next;
            ws_reg      <= ws_next;
            debt_reg    <= debt_next;
            compute_reg <= compute_next;
            idle_reg    <= idle_next;
            sleeps_reg  <= sleeps_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (rdy3) begin
            m_data.compute_us  <= compute_next;
            m_data.idle_us     <= idle_next;
            m_data.wall_us     <= enable_reg ? TW'(cur_next) : '0;
            m_data.debt_us     <= debt_next;
            m_data.sleep_count <= sleeps_next;
            m_data.span_error  <= err3_reg;
            m_data.last_result <= last3_reg;
        end
    end

    // An ignored event leaves the debt untouched.
    a_err_keeps_debt: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire3 && err3_reg) |=> $stable(debt_reg))
        else $error("debt changed on an ignored event");

    // Charged work never leaves the debt above the ceiling in force.
    a_debt_ceiling: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire3 && !err3_reg && enable_reg && !zero3_reg && kind3_reg == dcdl_pkg::KIND_WORK)
        |=> (debt_reg <= $past(debt_cap_reg)))
        else $error("debt above ceiling after charged work");

    // While disabled, debt and totals hold.
    a_disabled_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire3 && !enable_reg) |=> ($stable(debt_reg) && $stable(compute_reg)
                                    && $stable(idle_reg) && $stable(sleeps_reg)))
        else $error("state changed while disabled");

    // The sleep counter moves by at most one per cycle.
    a_sleep_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (sleeps_reg == $past(sleeps_reg)) || (sleeps_reg == $past(sleeps_reg) + DW'(1)))
        else $error("sleep counter jumped");

endmodule

`default_nettype wire
